@@ hw/rtl/mrrc_pkg.sv @@
// Shared types, constants and the CRC byte update for the Modbus RTU response checker.
package mrrc_pkg;

	localparam int unsigned MIN_FRAME = 7;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'hF8;
	localparam logic [7:0] FUNCTION_CODE_RESET = 8'h04;
	localparam logic [7:0] MIN_BYTE_COUNT      = 8'd2;

	// Byte positions inside a response frame.
	localparam int unsigned POS_ADDRESS  = 0;
	localparam int unsigned POS_FUNCTION = 1;
	localparam int unsigned POS_COUNT    = 2;
	localparam int unsigned POS_REG_HIGH = 3;
	localparam int unsigned POS_REG_LOW  = 4;
	localparam int unsigned CRC_LAG      = 2;

	localparam int unsigned OUT_DATA_W = 24;

	typedef enum logic [0:0] {
		REG_SLAVE_ADDRESS = 1'b0,
		REG_FUNCTION_CODE = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_SHORT  = 2'd1,
		STATUS_CRC    = 2'd2,
		STATUS_HEADER = 2'd3
	} status_t;

	// One byte of CRC-16/MODBUS, bit by bit, LSB first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

@@ hw/rtl/modbus_rtu_response_checker.sv @@
// Modbus RTU response checker: frame length, CRC-16 and header checks in one pass.
//
// Input stream (s_*): one received byte per transfer in s_tdata. s_tuser is high when
// the transfer carries a byte; s_tlast closes the frame after this transfer. A transfer
// with s_tlast high and s_tuser low is a timeout mark that adds no byte.
// Output stream (m_*): one result per closed frame, status in m_tdata[1:0] and the first
// register (tenths of a watt, zero unless status is OK) in m_tdata[17:2].
// Configuration: cfg_we writes cfg_wdata to the register at cfg_addr (0 slave address,
// 1 function code); the user must write only while no frame is in flight (unenforced).
// Pipeline: a transfer is held in an input register and handled from there, where the
// byte-wide CRC update, the header compares and the final verdict all settle.
// The verdict of a closing transfer is registered in the output register that drives
// m_tvalid. One transfer is taken every cycle while no closing transfer waits for the
// output register. Only the first MAX_FRAME bytes of a frame count.
// Stall: the result sits in the output register until taken; the input register keeps
// accepting bytes that do not close a frame, and a closing transfer waits there until the
// output register is free, which then holds s_tready low.
// Reset: clears all frame state, both valid flags, and loads the register defaults.
module modbus_rtu_response_checker #(
	parameter int unsigned MAX_FRAME = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [mrrc_pkg::OUT_DATA_W-1:0] m_tdata, // [1:0] status, [17:2] register_value
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	localparam int unsigned CW = $clog2(MAX_FRAME + 1);

	logic [7:0] slave_address_q;
	logic [7:0] function_code_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       end_s1;

	logic [CW-1:0] count_q;
	logic [15:0]   crc_q;
	logic [15:0]   tail_q;
	logic          header_ok_q;
	logic [15:0]   register_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [15:0] value_q;

	logic          go_s1;
	logic          take;
	logic [CW-1:0] count_n;
	logic [15:0]   crc_n;
	logic [15:0]   tail_n;
	logic          header_ok_n;
	logic [15:0]   register_n;
	logic [15:0]   crc_rx;
	mrrc_pkg::status_t status_n;

	assign go_s1    = valid_s1 && (!end_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= mrrc_pkg::SLAVE_ADDRESS_RESET;
			function_code_q <= mrrc_pkg::FUNCTION_CODE_RESET;
		end else if (cfg_we) begin
			unique case (mrrc_pkg::reg_index_t'(cfg_addr))
				mrrc_pkg::REG_SLAVE_ADDRESS: slave_address_q <= cfg_wdata;
				mrrc_pkg::REG_FUNCTION_CODE: function_code_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1    <= s_tdata;
			present_s1 <= s_tuser;
			end_s1     <= s_tlast;
		end
	end

	always_comb begin
		take        = present_s1 && (count_q < CW'(MAX_FRAME));
		count_n     = count_q;
		crc_n       = crc_q;
		tail_n      = tail_q;
		header_ok_n = header_ok_q;
		register_n  = register_q;
		if (take) begin
			count_n = count_q + CW'(1);
			tail_n  = {tail_q[7:0], byte_s1};
			if (count_q >= CW'(mrrc_pkg::CRC_LAG)) begin
				crc_n = mrrc_pkg::crc_feed(crc_q, tail_q[15:8]);
			end
			if (count_q == CW'(mrrc_pkg::POS_ADDRESS) && byte_s1 != slave_address_q) begin
				header_ok_n = 1'b0;
			end
			if (count_q == CW'(mrrc_pkg::POS_FUNCTION) && byte_s1 != function_code_q) begin
				header_ok_n = 1'b0;
			end
			if (count_q == CW'(mrrc_pkg::POS_COUNT) && byte_s1 < mrrc_pkg::MIN_BYTE_COUNT) begin
				header_ok_n = 1'b0;
			end
			if (count_q == CW'(mrrc_pkg::POS_REG_HIGH)) begin
				register_n = {byte_s1, 8'h00};
			end
			if (count_q == CW'(mrrc_pkg::POS_REG_LOW)) begin
				register_n = {register_q[15:8], byte_s1};
			end
		end

		// The received CRC travels low byte first, so the tail is byte swapped.
		crc_rx = {tail_n[7:0], tail_n[15:8]};
		if (count_n < CW'(mrrc_pkg::MIN_FRAME)) begin
			status_n = mrrc_pkg::STATUS_SHORT;
		end else if (crc_n != crc_rx) begin
			status_n = mrrc_pkg::STATUS_CRC;
		end else if (!header_ok_n) begin
			status_n = mrrc_pkg::STATUS_HEADER;
		end else begin
			status_n = mrrc_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			crc_q       <= mrrc_pkg::CRC_INIT;
			tail_q      <= '0;
			header_ok_q <= 1'b1;
			register_q  <= '0;
		end else if (go_s1) begin
			if (end_s1) begin
				count_q     <= '0;
				crc_q       <= mrrc_pkg::CRC_INIT;
				tail_q      <= '0;
				header_ok_q <= 1'b1;
				register_q  <= '0;
			end else begin
				count_q     <= count_n;
				crc_q       <= crc_n;
				tail_q      <= tail_n;
				header_ok_q <= header_ok_n;
				register_q  <= register_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && end_s1) begin
			status_q <= status_n;
			value_q  <= (status_n == mrrc_pkg::STATUS_OK) ? register_n : 16'h0000;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(mrrc_pkg::OUT_DATA_W - 18){1'b0}}, value_q, status_q};

endmodule

@@ hw/rtl/mrrc_checker.sv @@
// Port-level assertions for the Modbus RTU response checker and their bind.
module mrrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [mrrc_pkg::OUT_DATA_W-1:0] m_tdata
);

	// A stalled result must stay put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A failed frame never carries a register value.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != mrrc_pkg::STATUS_OK) |-> m_tdata[17:2] == 16'h0000)
		else $error("register value on a failed frame");

	// Padding bits of the result stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[mrrc_pkg::OUT_DATA_W-1:18] == '0)
		else $error("nonzero padding in result");

	// A fresh result follows an earlier closing transfer.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result without a closing transfer");

endmodule

bind modbus_rtu_response_checker mrrc_checker u_mrrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/mrrc_verdict_checker.sv @@
`timescale 1ns / 1ps
// Verdict checker: watches both streams and the register port, predicts each frame verdict and compares.
module mrrc_verdict_checker
	import mrrc_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  logic                  s_tuser,   // [0] byte_present
	input  logic                  s_tlast,   // frame_end
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] status, [17:2] register_value
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_addr,
	input  logic [7:0]            cfg_wdata,
	output int unsigned           mismatches,
	output int unsigned           outstanding
);

	localparam int unsigned CW = $clog2(MAX_FRAME + 1);

	typedef struct packed {
		status_t     status;
		logic [15:0] power;
	} verdict_t;

	verdict_t    verdict_q[$];
	logic [7:0]  want_address;
	logic [7:0]  want_function;
	logic [CW-1:0] kept;
	logic [15:0] crc_acc;
	logic [15:0] last_two;
	logic        hdr_good;
	logic [15:0] reg_word;

	// Serial form of CRC-16/MODBUS: each data bit joins the feedback as it reaches bit 0.
	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			r = {1'b0, r[15:1]} ^ ((r[0] ^ b[k]) ? CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

	task automatic clear_frame();
		kept     = '0;
		crc_acc  = CRC_INIT;
		last_two = 16'h0000;
		hdr_good = 1'b1;
		reg_word = 16'h0000;
	endtask

	// The CRC trails the input by two bytes, so at frame end the last two are the received CRC.
	task automatic absorb_byte(input logic [7:0] b);
		if (kept < MAX_FRAME) begin
			if (kept >= CRC_LAG) begin
				crc_acc = crc16_byte(crc_acc, last_two[15:8]);
			end
			last_two = {last_two[7:0], b};
			if (kept == POS_ADDRESS && b != want_address) begin
				hdr_good = 1'b0;
			end
			if (kept == POS_FUNCTION && b != want_function) begin
				hdr_good = 1'b0;
			end
			if (kept == POS_COUNT && b < MIN_BYTE_COUNT) begin
				hdr_good = 1'b0;
			end
			if (kept == POS_REG_HIGH) begin
				reg_word = {b, 8'h00};
			end
			if (kept == POS_REG_LOW) begin
				reg_word[7:0] = b;
			end
			kept = kept + 1'b1;
		end
	endtask

	task automatic close_frame();
		verdict_t v;
		v.power = 16'h0000;
		if (kept < MIN_FRAME) begin
			v.status = STATUS_SHORT;
		end else if (crc_acc != {last_two[7:0], last_two[15:8]}) begin
			v.status = STATUS_CRC;
		end else if (!hdr_good) begin
			v.status = STATUS_HEADER;
		end else begin
			v.status = STATUS_OK;
			v.power  = reg_word;
		end
		verdict_q.push_back(v);
		clear_frame();
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		if (!arst_n) begin
			want_address  = SLAVE_ADDRESS_RESET;
			want_function = FUNCTION_CODE_RESET;
			verdict_q.delete();
			clear_frame();
			mismatches    = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					absorb_byte(s_tdata);
				end
				if (s_tlast) begin
					close_frame();
				end
			end
			if (cfg_we) begin
				case (reg_index_t'(cfg_addr))
					REG_SLAVE_ADDRESS: want_address = cfg_wdata;
					REG_FUNCTION_CODE: want_function = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					report("unrequested verdict", 32'(m_tdata), 32'h0);
				end else begin
					v = verdict_q.pop_front();
					if (m_tdata[1:0] !== v.status) begin
						report("status", 32'(m_tdata[1:0]), 32'(v.status));
					end
					if (m_tdata[17:2] !== v.power) begin
						report("register_value", 32'(m_tdata[17:2]), 32'(v.power));
					end
				end
			end
		end
		outstanding = verdict_q.size();
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, response frame stimulus, output stalls and the final verdict.
module tb_top;
	import mrrc_pkg::*;

	localparam int unsigned MAX_FRAME   = 32;
	localparam int unsigned PIPE_CYCLES = 4;
	localparam int unsigned ITEM_GOAL   = 1300;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [7:0] rx_byte
	logic                  s_tuser;   // [0] byte_present
	logic                  s_tlast;   // frame_end
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // [1:0] status, [17:2] register_value
	logic                  cfg_we;
	logic [0:0]            cfg_addr;
	logic [7:0]            cfg_wdata;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned items_sent;
	int unsigned rx_hold;
	bit          tx_quiet;
	bit          rx_quiet;
	logic [7:0]  cur_address;
	logic [7:0]  cur_function;
	logic [7:0]  frame_bytes[$];

	modbus_rtu_response_checker #(.MAX_FRAME(MAX_FRAME)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	mrrc_verdict_checker #(.MAX_FRAME(MAX_FRAME)) u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Result side: a random stall before each transfer, or one long hold-off when requested.
	initial begin : sink
		int unsigned stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_quiet ? 0 : $urandom_range(0, 19);
			if (rx_hold != 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic present, input logic last);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 19);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= present;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (present || last) begin
			items_sent++;
		end
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_SLAVE_ADDRESS) begin
			cur_address = value;
		end else begin
			cur_function = value;
		end
	endtask

	// Registers change only once every verdict is out and the pipeline has drained.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (PIPE_CYCLES) @(negedge clk);
	endtask

	// Builds a well-formed response in frame_bytes, CRC appended low byte first.
	task automatic build_response(input logic [7:0] addr, input logic [7:0] func,
			input logic [7:0] cnt, input int unsigned n_data);
		logic [15:0] acc;
		frame_bytes = {addr, func, cnt};
		repeat (n_data) frame_bytes.push_back(8'($urandom_range(0, 255)));
		acc = CRC_INIT;
		foreach (frame_bytes[i]) begin
			acc ^= {8'h00, frame_bytes[i]};
			repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
		end
		frame_bytes.push_back(acc[7:0]);
		frame_bytes.push_back(acc[15:8]);
	endtask

	task automatic send_frame(input bit by_timeout);
		int unsigned n;
		n = frame_bytes.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			send_item(frame_bytes[i], 1'b1, !by_timeout && i == n - 1);
		end
		if (by_timeout) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	task automatic random_frame();
		int unsigned kind;
		int unsigned n_data;
		int unsigned idx;
		logic [7:0]  cnt;
		bit          by_timeout;
		kind       = $urandom_range(0, 99);
		n_data     = ($urandom_range(0, 15) == 0) ? $urandom_range(2, MAX_FRAME - 5)
		                                          : $urandom_range(2, 6);
		cnt        = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255)) : 8'(n_data);
		by_timeout = 1'b0;
		build_response(cur_address, cur_function, cnt, n_data);
		if (kind < 55) begin
			// well-formed response
		end else if (kind < 65) begin
			idx = $urandom_range(0, frame_bytes.size() - 1);
			frame_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
		end else if (kind < 75) begin
			// Good CRC over a header that must be rejected.
			case ($urandom_range(0, 2))
				0: build_response(cur_address ^ 8'($urandom_range(1, 255)), cur_function,
						cnt, n_data);
				1: build_response(cur_address, cur_function ^ 8'($urandom_range(1, 255)),
						cnt, n_data);
				default: build_response(cur_address, cur_function,
						8'($urandom_range(0, 1)), n_data);
			endcase
		end else if (kind < 83) begin
			frame_bytes = frame_bytes[0:$urandom_range(0, 5)];
			if ($urandom_range(0, 3) == 0) begin
				frame_bytes.delete();
			end
			by_timeout = (frame_bytes.size() == 0) || ($urandom_range(0, 1) == 0);
		end else if (kind < 90) begin
			// The first MAX_FRAME bytes form a valid response, the rest must be ignored.
			build_response(cur_address, cur_function, cnt, MAX_FRAME - 5);
			repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom_range(0, 255)));
			by_timeout = 1'($urandom_range(0, 1));
		end else if (kind < 95) begin
			frame_bytes.delete();
			repeat ($urandom_range(0, MAX_FRAME + 4)) begin
				frame_bytes.push_back(8'($urandom_range(0, 255)));
			end
			by_timeout = (frame_bytes.size() == 0) || ($urandom_range(0, 1) == 0);
		end else begin
			by_timeout = 1'b1;
		end
		send_frame(by_timeout);
	endtask

	initial begin : stimulus
		int unsigned phase;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tuser      = 1'b0;
		s_tlast      = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = REG_SLAVE_ADDRESS;
		cfg_wdata    = 8'h00;
		items_sent   = 0;
		rx_hold      = 0;
		tx_quiet     = 1'b0;
		rx_quiet     = 1'b0;
		cur_address  = SLAVE_ADDRESS_RESET;
		cur_function = FUNCTION_CODE_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle item, lone timeout, good frame, short frame, corrupted CRC.
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		build_response(cur_address, cur_function, 8'd2, 2);
		frame_bytes[3] = 8'hFF;
		frame_bytes[4] = 8'h00;
		build_response(frame_bytes[0], frame_bytes[1], frame_bytes[2], 0);
		frame_bytes = {cur_address, cur_function, 8'd2, 8'hFF, 8'h00};
		build_response(cur_address, cur_function, 8'd2, 2);
		frame_bytes[3] = 8'hFF;
		frame_bytes[4] = 8'h00;
		frame_bytes = frame_bytes[0:4];
		begin
			logic [15:0] acc;
			acc = CRC_INIT;
			foreach (frame_bytes[i]) begin
				acc ^= {8'h00, frame_bytes[i]};
				repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
			end
			frame_bytes.push_back(acc[7:0]);
			frame_bytes.push_back(acc[15:8]);
		end
		send_frame(1'b0);
		frame_bytes = {cur_address, cur_function, 8'd2};
		send_frame(1'b1);
		build_response(cur_address, cur_function, 8'd2, 2);
		frame_bytes[6] ^= 8'h80;
		send_frame(1'b0);

		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			wait_idle();
			if (phase == 0) begin
				write_reg(REG_SLAVE_ADDRESS, 8'h00);
				write_reg(REG_FUNCTION_CODE, 8'h00);
			end else if (phase == 1) begin
				write_reg(REG_SLAVE_ADDRESS, 8'hFF);
				write_reg(REG_FUNCTION_CODE, 8'hFF);
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						write_reg(REG_SLAVE_ADDRESS, SLAVE_ADDRESS_RESET);
						write_reg(REG_FUNCTION_CODE, FUNCTION_CODE_RESET);
					end
					1: write_reg(REG_SLAVE_ADDRESS, 8'($urandom_range(0, 255)));
					2: write_reg(REG_FUNCTION_CODE, 8'($urandom_range(0, 255)));
					default: ;
				endcase
			end
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 3) begin
				// Back-to-back frames against a long output stall fill the block up.
				tx_quiet = 1'b1;
				rx_hold  = 300;
				repeat (12) begin
					build_response(cur_address, cur_function, 8'd2, 2);
					send_frame(1'b0);
				end
				tx_quiet = 1'b0;
			end
			repeat ($urandom_range(8, 20)) random_frame();
			phase++;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (PIPE_CYCLES * 4) @(negedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
